/* rtl/core/hds_pkg.sv */
// Shared types, constants and helper functions for the 1D heat diffusion stencil.
package hds_pkg;

	// Row storage geometry.
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int NPTS_W     = ADDR_W + 1;

	// Fixed field widths.
	localparam int VAL_W   = 24;
	localparam int COEF_W  = 16;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 24;

	// Arithmetic widths of the point update.
	localparam int LAP_W  = VAL_W + 2;
	localparam int PROD_W = LAP_W + COEF_W + 1;
	localparam int RND_W  = PROD_W + 1;
	localparam int DELTA_W = RND_W - COEF_W;
	localparam int SUM_W  = DELTA_W + 1;

	// Decoupling queue depth.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request type codes.
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_ADVANCE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_COEF_R         = 2'd0;
	localparam logic [1:0] REG_BOUNDARY_LEFT  = 2'd1;
	localparam logic [1:0] REG_BOUNDARY_RIGHT = 2'd2;
	localparam logic [1:0] REG_NUM_POINTS     = 2'd3;

	// Configuration reset values.
	localparam logic [COEF_W-1:0]       COEF_R_RST         = 16'd13271;
	localparam logic signed [VAL_W-1:0] BOUNDARY_LEFT_RST  = 24'sd65536;
	localparam logic signed [VAL_W-1:0] BOUNDARY_RIGHT_RST = -24'sd65536;
	localparam logic [NPTS_W-1:0]       NUM_POINTS_RST     = 11'd100;

	// Saturation limits.
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Classified operation handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_ADVANCE,
		OP_READ_MEM,
		OP_READ_LEFT,
		OP_READ_RIGHT,
		OP_REJECT
	} op_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PRIME,
		ST_LOAD,
		ST_WALK,
		ST_DRAIN
	} state_t;

	// One queued work item.
	typedef struct packed {
		op_t                      op;
		logic [ADDR_W-1:0]        idx;
		logic signed [VAL_W-1:0]  sample;
		logic [COUNT_W-1:0]       count;
	} work_t;

	// Configuration as seen by the front and back ends.
	typedef struct packed {
		logic [COEF_W-1:0]        coef_r;
		logic signed [VAL_W-1:0]  boundary_left;
		logic signed [VAL_W-1:0]  boundary_right;
		logic [NPTS_W-1:0]        num_points;
	} cfg_t;

	// Point count clamped to the supported range.
	function automatic logic [NPTS_W-1:0] points_in_use(input logic [NPTS_W-1:0] n);
		logic [NPTS_W-1:0] res;
		res = n;
		if (n < NPTS_W'(3)) begin
			res = NPTS_W'(3);
		end else if (n > NPTS_W'(MAX_POINTS)) begin
			res = NPTS_W'(MAX_POINTS);
		end
		return res;
	endfunction

endpackage

/* rtl/core/hds_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module hds_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/hds_front.sv */
// Front end: takes request transfers and classifies them into work items.
module hds_front import hds_pkg::*; (
	input  logic                     in_valid,
	input  logic [1:0]               req_type,
	input  logic [ADDR_W-1:0]        point_index,
	input  logic signed [VAL_W-1:0]  sample_value,
	input  logic [COUNT_W-1:0]       step_count,
	input  cfg_t                     cfg,
	input  logic                     q_full,
	output logic                     in_stall,
	output logic                     push,
	output work_t                    push_data
);

	logic [NPTS_W-1:0] npts;
	logic [NPTS_W-1:0] idx_ext;

	assign npts    = points_in_use(cfg.num_points);
	assign idx_ext = NPTS_W'(point_index);

	// The queue takes a transfer whenever it has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Classify the request against the row in use.
	always_comb begin
		push_data.idx    = point_index;
		push_data.sample = sample_value;
		push_data.count  = step_count;
		push_data.op     = OP_REJECT;
		unique case (req_type)
			REQ_LOAD: begin
				if (idx_ext >= NPTS_W'(1) && idx_ext + NPTS_W'(1) < npts) begin
					push_data.op = OP_LOAD;
				end
			end
			REQ_ADVANCE: begin
				push_data.op = OP_ADVANCE;
			end
			REQ_READ: begin
				if (idx_ext == '0) begin
					push_data.op = OP_READ_LEFT;
				end else if (idx_ext + NPTS_W'(1) == npts) begin
					push_data.op = OP_READ_RIGHT;
				end else if (idx_ext < npts) begin
					push_data.op = OP_READ_MEM;
				end
			end
			default: begin
				push_data.op = OP_REJECT;
			end
		endcase
	end

endmodule

/* rtl/core/hds_queue.sv */
// Short FIFO that decouples the front end from the back end.
module hds_queue import hds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output work_t pop_data
);

	work_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/hds_back.sv */
// Back end: executes work items, walks the row for time steps and holds the result.
module hds_back import hds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_valid,
	input  work_t                    q_data,
	output logic                     q_pop,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [VAL_W-1:0]  read_value,
	output logic                     status
);

	state_t state_q, next_state;

	// Walk registers.
	logic [COUNT_W-1:0]       steps_left_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [VAL_W-1:0]  left_q;
	logic signed [VAL_W-1:0]  center_q;

	// Update pipeline.
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [VAL_W-1:0]  c_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic                     vld_s1;

	// Result register.
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  read_value_q;
	logic                     status_q;

	// RAM ports.
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [VAL_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [VAL_W-1:0]         ram_rdata;

	logic [NPTS_W-1:0]        npts;
	logic                     take;
	logic                     last_point;
	logic signed [VAL_W-1:0]  rt;
	logic signed [LAP_W-1:0]  lap;
	logic signed [PROD_W-1:0] prod;
	logic [RND_W-1:0]         rnd;
	logic [DELTA_W-1:0]       delta;
	logic [SUM_W-1:0]         sum;
	logic signed [VAL_W-1:0]  upd_value;
	logic                     fin;
	logic signed [VAL_W-1:0]  fin_value;
	logic                     fin_status;

	hds_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_POINTS)
	) u_row (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign npts = points_in_use(cfg.num_points);

	// A new item starts only when the result register is free or drains now.
	assign take  = (state_q == ST_IDLE) && q_valid && (!out_valid_q || !out_stall);
	assign q_pop = take;

	// The right neighbor of the last interior point is the right boundary.
	assign last_point = (NPTS_W'(pos_q) + NPTS_W'(2) == npts);
	assign rt = last_point ? cfg.boundary_right : $signed(ram_rdata);

	// First stage: Laplacian times r.
	assign lap  = {{2{left_q[VAL_W-1]}}, left_q} - {center_q[VAL_W-1], center_q, 1'b0}
		+ {{2{rt[VAL_W-1]}}, rt};
	assign prod = lap * $signed({1'b0, cfg.coef_r});

	// Second stage: round to nearest, add the center and saturate.
	always_comb begin
		rnd   = {prod_s1[PROD_W-1], prod_s1} + RND_W'(1 << (COEF_W - 1));
		delta = rnd[RND_W-1:COEF_W];
		sum   = {{(SUM_W-VAL_W){c_s1[VAL_W-1]}}, c_s1} + {delta[DELTA_W-1], delta};
		if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
			upd_value = sum[VAL_W-1:0];
		end else if (sum[SUM_W-1]) begin
			upd_value = VAL_MIN;
		end else begin
			upd_value = VAL_MAX;
		end
	end

	// Next state.
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (q_data.op == OP_ADVANCE && q_data.count != '0) begin
						next_state = ST_PRIME;
					end else if (q_data.op == OP_READ_MEM) begin
						next_state = ST_READ;
					end
				end
			end
			ST_READ:  next_state = ST_IDLE;
			ST_PRIME: next_state = ST_LOAD;
			ST_LOAD:  next_state = ST_WALK;
			ST_WALK: begin
				if (last_point) begin
					next_state = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				next_state = (steps_left_q == COUNT_W'(1)) ? ST_IDLE : ST_PRIME;
			end
			default: next_state = ST_IDLE;
		endcase
	end

	// Outputs: RAM port control and result completion.
	always_comb begin
		ram_raddr  = q_data.idx;
		ram_we     = vld_s1;
		ram_waddr  = addr_s1;
		ram_wdata  = upd_value;
		fin        = 1'b0;
		fin_value  = '0;
		fin_status = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (q_data.op)
						OP_LOAD: begin
							ram_we    = 1'b1;
							ram_waddr = q_data.idx;
							ram_wdata = q_data.sample;
							fin       = 1'b1;
						end
						OP_ADVANCE: begin
							fin = (q_data.count == '0);
						end
						OP_READ_LEFT: begin
							fin       = 1'b1;
							fin_value = cfg.boundary_left;
						end
						OP_READ_RIGHT: begin
							fin       = 1'b1;
							fin_value = cfg.boundary_right;
						end
						OP_READ_MEM: begin
							fin = 1'b0;
						end
						default: begin
							fin        = 1'b1;
							fin_status = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin       = 1'b1;
				fin_value = ram_rdata;
			end
			ST_PRIME: ram_raddr = ADDR_W'(1);
			ST_LOAD:  ram_raddr = ADDR_W'(2);
			ST_WALK:  ram_raddr = pos_q + ADDR_W'(2);
			ST_DRAIN: fin = (steps_left_q == COUNT_W'(1));
			default:  fin = 1'b0;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			steps_left_q <= '0;
			pos_q        <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= next_state;
			vld_s1  <= (state_q == ST_WALK);
			if (take && q_data.op == OP_ADVANCE) begin
				steps_left_q <= q_data.count;
			end else if (state_q == ST_DRAIN) begin
				steps_left_q <= steps_left_q - 1'b1;
			end
			if (state_q == ST_LOAD) begin
				pos_q <= ADDR_W'(1);
			end else if (state_q == ST_WALK) begin
				pos_q <= pos_q + 1'b1;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk data, update pipeline and result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_PRIME) begin
			left_q <= cfg.boundary_left;
		end else if (state_q == ST_WALK) begin
			left_q <= center_q;
		end
		if (state_q == ST_LOAD) begin
			center_q <= ram_rdata;
		end else if (state_q == ST_WALK) begin
			center_q <= rt;
		end
		prod_s1 <= prod;
		c_s1    <= center_q;
		addr_s1 <= pos_q;
		if (fin) begin
			read_value_q <= fin_value;
			status_q     <= fin_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

/* rtl/core/heat_diffusion_stencil_1d.sv */
// Top level of the 1D heat diffusion stencil: configuration registers and the two halves.
//
// Usage: requests arrive on the in channel (in_valid / in_stall) with req_type,
// point_index, sample_value and step_count. Each request gives exactly one
// result transfer on the out channel (out_valid / out_stall): read_value and status.
// A two-entry queue separates request intake from execution, so requests are
// taken while a result waits for the receiver.
// A load, a rejected request, a zero-step advance or a boundary read completes as it is
// taken from the queue; a read of an interior point first passes the READ state for the
// registered RAM read. An advance makes one pass of the single-port-read row RAM per
// time step, through PRIME, LOAD, WALK (one interior point per cycle) and DRAIN.
// Items run one at a time: loads and boundary reads can follow every cycle while
// out_stall is low.
// When out_stall is high the result is held; the queue fills, after which
// in_stall rises. Configuration writes through cfg_we / cfg_index / cfg_data take
// effect at once; the user is to make them only while the block is idle, which the
// block itself does not enforce. Reset (arst_n low) empties the queue, drops any
// pending result and restores the configuration defaults. The row contents are not
// cleared: the user must have loaded every interior point before the first advance, unchecked.
module heat_diffusion_stencil_1d import hds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [ADDR_W-1:0]        point_index,
	input  logic signed [VAL_W-1:0]  sample_value,
	input  logic [COUNT_W-1:0]       step_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VAL_W-1:0]  read_value,
	output logic                     status
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	work_t q_push_data;
	logic  q_pop;
	logic  q_valid;
	work_t q_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_r         <= COEF_R_RST;
			cfg_q.boundary_left  <= BOUNDARY_LEFT_RST;
			cfg_q.boundary_right <= BOUNDARY_RIGHT_RST;
			cfg_q.num_points     <= NUM_POINTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_R:         cfg_q.coef_r         <= cfg_data[COEF_W-1:0];
				REG_BOUNDARY_LEFT:  cfg_q.boundary_left  <= cfg_data[VAL_W-1:0];
				REG_BOUNDARY_RIGHT: cfg_q.boundary_right <= cfg_data[VAL_W-1:0];
				REG_NUM_POINTS:     cfg_q.num_points     <= cfg_data[NPTS_W-1:0];
			endcase
		end
	end

	hds_front u_front (
		.in_valid     (in_valid),
		.req_type     (req_type),
		.point_index  (point_index),
		.sample_value (sample_value),
		.step_count   (step_count),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.in_stall     (in_stall),
		.push         (q_push),
		.push_data    (q_push_data)
	);

	hds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	hds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.read_value (read_value),
		.status     (status)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the 1D heat diffusion stencil with a row-tracking scoreboard.
`timescale 1ns / 100ps

module testbench;
	import hds_pkg::*;

	// Request code with no meaning to the block; it must be rejected.
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    flag;
	} heat_reply_t;

	// Scoreboard: mirrors the configuration and the row, and holds the replies still due.
	class heat_row_scoreboard;
		logic [COEF_W-1:0]       coef;
		logic signed [VAL_W-1:0] temp_left;
		logic signed [VAL_W-1:0] temp_right;
		logic [NPTS_W-1:0]       npts_reg;
		logic signed [VAL_W-1:0] row [MAX_POINTS];
		heat_reply_t             pending_replies [$];
		int                      errors;

		function new();
			coef       = COEF_R_RST;
			temp_left  = BOUNDARY_LEFT_RST;
			temp_right = BOUNDARY_RIGHT_RST;
			npts_reg   = NUM_POINTS_RST;
			errors     = 0;
		endfunction

		function void write_config(logic [1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_COEF_R:         coef       = data[COEF_W-1:0];
				REG_BOUNDARY_LEFT:  temp_left  = data[VAL_W-1:0];
				REG_BOUNDARY_RIGHT: temp_right = data[VAL_W-1:0];
				REG_NUM_POINTS:     npts_reg   = data[NPTS_W-1:0];
				default: ;
			endcase
		endfunction

		// The point count register is used clamped to the supported range.
		function int points_used();
			int n;
			n = int'(npts_reg);
			if (n < 3) n = 3;
			if (n > MAX_POINTS) n = MAX_POINTS;
			return n;
		endfunction

		// One FTCS update with round-half-up and saturation to the value range.
		function logic signed [VAL_W-1:0] stencil_point(logic signed [VAL_W-1:0] l,
				logic signed [VAL_W-1:0] c, logic signed [VAL_W-1:0] rt);
			longint lap;
			longint acc;
			longint sum;
			lap = longint'(l) - 2 * longint'(c) + longint'(rt);
			acc = lap * longint'(coef) + (longint'(1) << (COEF_W - 1));
			sum = longint'(c) + (acc >>> COEF_W);
			if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
			if (sum < longint'(VAL_MIN)) sum = longint'(VAL_MIN);
			return sum[VAL_W-1:0];
		endfunction

		// In-place walk over the interior, keeping the old left neighbor.
		function void advance_row(int unsigned steps);
			int n;
			logic signed [VAL_W-1:0] prev;
			logic signed [VAL_W-1:0] cur;
			logic signed [VAL_W-1:0] nxt;
			n = points_used();
			repeat (steps) begin
				prev = temp_left;
				for (int p = 1; p + 1 < n; p++) begin
					nxt = (p + 2 == n) ? temp_right : row[p+1];
					cur = row[p];
					row[p] = stencil_point(prev, cur, nxt);
					prev = cur;
				end
			end
		endfunction

		// Called for every accepted request; queues the reply it must produce.
		function void note_request(logic [1:0] kind, logic [ADDR_W-1:0] idx,
				logic signed [VAL_W-1:0] sample, logic [COUNT_W-1:0] count);
			int n;
			int i;
			heat_reply_t r;
			n = points_used();
			i = int'(idx);
			r.value = '0;
			r.flag  = 1'b0;
			case (kind)
				REQ_LOAD: begin
					if (i >= 1 && i + 1 < n) row[i] = sample;
					else r.flag = 1'b1;
				end
				REQ_ADVANCE: advance_row(int'(count));
				REQ_READ: begin
					if (i == 0) r.value = temp_left;
					else if (i + 1 == n) r.value = temp_right;
					else if (i < n) r.value = row[i];
					else r.flag = 1'b1;
				end
				default: r.flag = 1'b1;
			endcase
			pending_replies.push_back(r);
		endfunction

		// Called for every result transfer; compares it with the oldest reply due.
		function void check_reply(logic signed [VAL_W-1:0] value, logic flag);
			heat_reply_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, read_value %0d status %0b", $time, value, flag);
				return;
			end
			want = pending_replies.pop_front();
			if (value !== want.value) begin
				errors++;
				$display("%0t: read_value mismatch, expected %0d, actual %0d",
					$time, want.value, value);
			end
			if (flag !== want.flag) begin
				errors++;
				$display("%0t: status mismatch, expected %0b, actual %0b",
					$time, want.flag, flag);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              req_type;
	logic [ADDR_W-1:0]       point_index;
	logic signed [VAL_W-1:0] sample_value;
	logic [COUNT_W-1:0]      step_count;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [VAL_W-1:0] read_value;
	logic                    status;

	heat_row_scoreboard sb = new();
	bit                 steady;
	bit                 loaded [MAX_POINTS];
	int                 sent_items;

	heat_diffusion_stencil_1d DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.point_index  (point_index),
		.sample_value (sample_value),
		.step_count   (step_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit, several times the slowest legal run.
	initial begin
		#40000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls, none during the steady stretch.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 22);
	end

	// Result monitor: every result transfer goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_reply(read_value, status);
	end

	// Temperature with the extremes of the range mixed in.
	function automatic logic signed [VAL_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Present one request, with random idle cycles first, and hold it until transfer.
	task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] idx,
			input logic signed [VAL_W-1:0] sample, input logic [COUNT_W-1:0] count);
		while (!steady && $urandom_range(0, 99) < 22) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid     = 1'b1;
		req_type     = kind;
		point_index  = idx;
		sample_value = sample;
		step_count   = count;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(kind, idx, sample, count);
		sent_items++;
		if (kind == REQ_LOAD && idx >= 1 && int'(idx) + 1 < sb.points_used()) loaded[idx] = 1'b1;
	endtask

	// Stop sending and wait until every reply due has arrived.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	// Write all four registers while the block is idle.
	task automatic set_config(input logic [CFG_W-1:0] c0, input logic [CFG_W-1:0] c1,
			input logic [CFG_W-1:0] c2, input logic [CFG_W-1:0] c3);
		logic [1:0]       regs [4] = '{REG_COEF_R, REG_BOUNDARY_LEFT, REG_BOUNDARY_RIGHT,
			REG_NUM_POINTS};
		logic [CFG_W-1:0] vals [4];
		vals = '{c0, c1, c2, c3};
		drain_results();
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_index = regs[i];
			cfg_data  = vals[i];
			sb.write_config(regs[i], vals[i]);
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Load every interior point that has never been written.
	task automatic fill_row(input int n);
		for (int p = 1; p + 1 < n; p++) begin
			if (!loaded[p]) send_request(REQ_LOAD, ADDR_W'(p), pick_sample(), COUNT_W'($urandom));
		end
	endtask

	// One random request: mostly well-formed work, some rejected or unknown ones.
	task automatic random_request(input int n);
		int                      pick;
		logic [1:0]              kind;
		logic [ADDR_W-1:0]       idx;
		logic signed [VAL_W-1:0] sample;
		logic [COUNT_W-1:0]      count;
		pick   = $urandom_range(0, 99);
		idx    = ADDR_W'($urandom);
		sample = pick_sample();
		count  = COUNT_W'($urandom);
		if (pick < 35) begin
			kind = REQ_LOAD;
			idx  = ADDR_W'($urandom_range(1, n - 2));
		end else if (pick < 60) begin
			kind = REQ_READ;
			if ($urandom_range(0, 3) != 0) idx = ADDR_W'($urandom_range(0, n - 1));
		end else if (pick < 82) begin
			kind  = REQ_ADVANCE;
			count = (n > 64) ? COUNT_W'($urandom_range(0, 2)) : COUNT_W'($urandom_range(0, 6));
		end else if (pick < 92) begin
			// Load at a boundary or beyond the row.
			kind = REQ_LOAD;
			case ($urandom_range(0, 2))
				0:       idx = '0;
				1:       idx = ADDR_W'(n - 1);
				default: idx = ADDR_W'($urandom_range(n - 1, MAX_POINTS - 1));
			endcase
		end else begin
			kind = REQ_UNKNOWN;
		end
		send_request(kind, idx, sample, count);
	endtask

	// Main sequence: reset, directed checks, then randomized phases.
	initial begin
		int               ph;
		int               per;
		int               n;
		logic [CFG_W-1:0] c_coef;
		logic [CFG_W-1:0] c_left;
		logic [CFG_W-1:0] c_right;
		logic [CFG_W-1:0] c_np;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		req_type     = '0;
		point_index  = '0;
		sample_value = '0;
		step_count   = '0;
		out_stall    = 1'b0;
		steady       = 1'b0;
		sent_items   = 0;
		ph           = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: boundary reads, boundary loads, reads and loads outside the row, unknown code.
		send_request(REQ_READ, ADDR_W'(0), '0, '0);
		send_request(REQ_READ, ADDR_W'(99), '0, '0);
		send_request(REQ_READ, ADDR_W'(100), '0, '0);
		send_request(REQ_READ, ADDR_W'(1023), '0, '0);
		send_request(REQ_LOAD, ADDR_W'(0), VAL_MAX, '0);
		send_request(REQ_LOAD, ADDR_W'(99), VAL_MIN, '0);
		send_request(REQ_LOAD, ADDR_W'(1023), VAL_MAX, '1);
		send_request(REQ_UNKNOWN, '1, VAL_MIN, '1);

		// Five points: extreme loads, read-back, a zero-step and a one-step advance.
		set_config(CFG_W'(COEF_R_RST), CFG_W'(BOUNDARY_LEFT_RST), CFG_W'(BOUNDARY_RIGHT_RST),
			CFG_W'(5));
		send_request(REQ_LOAD, ADDR_W'(1), VAL_MAX, '0);
		send_request(REQ_LOAD, ADDR_W'(2), VAL_MIN, '0);
		send_request(REQ_LOAD, ADDR_W'(3), '0, '0);
		send_request(REQ_READ, ADDR_W'(1), '0, '0);
		send_request(REQ_READ, ADDR_W'(2), '0, '0);
		send_request(REQ_READ, ADDR_W'(4), '0, '0);
		send_request(REQ_ADVANCE, '0, '0, COUNT_W'(0));
		send_request(REQ_ADVANCE, '0, '0, COUNT_W'(1));
		send_request(REQ_READ, ADDR_W'(2), '0, '0);

		// Point count below the minimum, r far above one half, extreme boundaries, longest advance.
		set_config(CFG_W'(16'hFFFF), CFG_W'(VAL_MAX), CFG_W'(VAL_MIN), CFG_W'(2));
		send_request(REQ_LOAD, ADDR_W'(1), VAL_MIN, '0);
		send_request(REQ_ADVANCE, '0, '0, '1);
		send_request(REQ_READ, ADDR_W'(0), '0, '0);
		send_request(REQ_READ, ADDR_W'(1), '0, '0);
		send_request(REQ_READ, ADDR_W'(2), '0, '0);
		send_request(REQ_READ, ADDR_W'(3), '0, '0);

		// Random phases, each with a fresh configuration.
		while (sent_items < 400) begin
			c_coef = CFG_W'($urandom);
			case ($urandom_range(0, 4))
				0:       c_coef[COEF_W-1:0] = '0;
				1:       c_coef[COEF_W-1:0] = COEF_W'(32768);
				2:       c_coef[COEF_W-1:0] = '1;
				default: c_coef[COEF_W-1:0] = COEF_W'($urandom_range(0, 32768));
			endcase
			c_left  = CFG_W'(pick_sample());
			c_right = CFG_W'(pick_sample());
			c_np    = CFG_W'($urandom);
			if (ph == 2) c_np[NPTS_W-1:0] = '1;
			else if (ph == 4) c_np[NPTS_W-1:0] = NPTS_W'(100);
			else if ($urandom_range(0, 9) == 0) c_np[NPTS_W-1:0] = NPTS_W'($urandom_range(0, 2));
			else c_np[NPTS_W-1:0] = NPTS_W'($urandom_range(3, 24));
			set_config(c_coef, c_left, c_right, c_np);

			steady = (ph == 1);
			n = sb.points_used();
			if (ph == 2) begin
				// Point count above the maximum: the row ends at the last address.
				send_request(REQ_READ, ADDR_W'(0), '0, '0);
				send_request(REQ_READ, ADDR_W'(MAX_POINTS - 1), '0, '0);
				send_request(REQ_LOAD, ADDR_W'(MAX_POINTS - 1), pick_sample(), '0);
				send_request(REQ_LOAD, ADDR_W'(1), pick_sample(), '0);
				send_request(REQ_READ, ADDR_W'(1), '0, '0);
				send_request(REQ_LOAD, ADDR_W'(MAX_POINTS - 2), pick_sample(), '0);
				send_request(REQ_READ, ADDR_W'(MAX_POINTS - 2), '0, '0);
			end else begin
				fill_row(n);
				per = (n > 64) ? 25 : $urandom_range(20, 45);
				for (int k = 0; k < per; k++) begin
					if (k == per / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) drain_results();
					random_request(n);
				end
			end
			ph++;
		end
		steady = 1'b0;

		// Wait for the last replies, then a few quiet cycles for stray results.
		drain_results();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/hds_pkg.sv
rtl/core/hds_ram.sv
rtl/core/hds_front.sv
rtl/core/hds_queue.sv
rtl/core/hds_back.sv
rtl/core/heat_diffusion_stencil_1d.sv
tb/testbench.sv
